// File: hw/rtl/epq_pkg.sv
// ----------------------------------------------------------------------------
// Event priority queue package
// Shared widths, codes, entry type and the event ordering function.
// ----------------------------------------------------------------------------
package epq_pkg;

   // Storage and field sizes.
   localparam int DEPTH  = 64;
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int TIME_W = 48;
   localparam int QID_W  = 8;
   localparam int KIND_W = 2;
   localparam int STAT_W = 2;

   // Event kinds.
   localparam logic [KIND_W-1:0] KIND_ARRIVAL   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEPARTURE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EXIT      = 2'd2;
   localparam logic [KIND_W-1:0] KIND_OTHER     = 2'd3;

   // Actions.
   localparam logic ACT_INSERT  = 1'b0;
   localparam logic ACT_EXTRACT = 1'b1;

   // Result status codes.
   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   // One stored event.
   typedef struct packed {
      logic [TIME_W-1:0] sched;
      logic [TIME_W-1:0] q_arr;
      logic [TIME_W-1:0] s_arr;
      logic [QID_W-1:0]  qid;
      logic [KIND_W-1:0] kind;
   } entry_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic comp;
      logic update;
   } cmd_type;

   // Ordering of a new event against a stored one: {earlier, not later}.
   function automatic logic [1:0] order_f(entry_type n, entry_type s);
      logic lt;
      logic le;
      begin
         if (n.sched != s.sched) begin
            lt = n.sched < s.sched;
            le = lt;
         end else if (n.q_arr != s.q_arr) begin
            lt = n.q_arr < s.q_arr;
            le = lt;
         end else if (n.s_arr != s.s_arr) begin
            lt = n.s_arr < s.s_arr;
            le = lt;
         end else if (n.qid != s.qid) begin
            lt = n.qid < s.qid;
            le = lt;
         end else if (n.kind == KIND_EXIT) begin
            lt = 1'b1;
            le = 1'b1;
         end else if (s.kind == KIND_EXIT) begin
            lt = 1'b0;
            le = 1'b0;
         end else if (n.kind == KIND_DEPARTURE) begin
            lt = 1'b1;
            le = 1'b1;
         end else if (s.kind == KIND_DEPARTURE) begin
            lt = 1'b0;
            le = 1'b0;
         end else begin
            lt = 1'b0;
            le = 1'b1;
         end
         return {lt, le};
      end
   endfunction

endpackage

// File: hw/rtl/epq_if.sv
// ----------------------------------------------------------------------------
// Event priority queue channels
// Request and response channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface epq_req_if;
   logic                         valid;
   logic                         ready;
   logic                         action;
   logic [epq_pkg::TIME_W-1:0]   scheduled_time;
   logic [epq_pkg::TIME_W-1:0]   queue_arrival_time;
   logic [epq_pkg::TIME_W-1:0]   system_arrival_time;
   logic [epq_pkg::QID_W-1:0]    queue_number;
   logic [epq_pkg::KIND_W-1:0]   event_kind;

   modport source (output valid, action, scheduled_time, queue_arrival_time,
                   system_arrival_time, queue_number, event_kind, input ready);
   modport sink   (input valid, action, scheduled_time, queue_arrival_time,
                   system_arrival_time, queue_number, event_kind, output ready);
endinterface

interface epq_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [epq_pkg::STAT_W-1:0]   status;
   logic [epq_pkg::TIME_W-1:0]   out_scheduled_time;
   logic [epq_pkg::TIME_W-1:0]   out_queue_arrival_time;
   logic [epq_pkg::TIME_W-1:0]   out_system_arrival_time;
   logic [epq_pkg::QID_W-1:0]    out_queue_number;
   logic [epq_pkg::KIND_W-1:0]   out_event_kind;
   logic [epq_pkg::CNT_W-1:0]    occupancy;

   modport source (output valid, status, out_scheduled_time, out_queue_arrival_time,
                   out_system_arrival_time, out_queue_number, out_event_kind,
                   occupancy, input ready);
   modport sink   (input valid, status, out_scheduled_time, out_queue_arrival_time,
                   out_system_arrival_time, out_queue_number, out_event_kind,
                   occupancy, output ready);
endinterface

// File: hw/rtl/event_priority_queue.sv
// ----------------------------------------------------------------------------
// Event priority queue
// Bounded sorted queue of simulation events with insert and extract.
// ----------------------------------------------------------------------------
//   Channel  Role    Word
//   req      sink    action and one event
//   rsp      source  status, extracted event, occupancy
//
// Each word passes through accept, compare in every cell, shift update,
// then the response is held until taken. Insert position comes from one
// comparator per cell and a prefix mask. Reset clears the entry count, not the cells.
// A stalled response holds the block; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module event_priority_queue (
   input logic      clock,
   input logic      reset,
   epq_req_if.sink  req_chan,
   epq_rsp_if.source rsp_chan
);

   epq_pkg::cmd_type   cmd;
   epq_pkg::entry_type req_entry;
   epq_pkg::entry_type rsp_entry;

   assign req_entry.sched = req_chan.scheduled_time;
   assign req_entry.q_arr = req_chan.queue_arrival_time;
   assign req_entry.s_arr = req_chan.system_arrival_time;
   assign req_entry.qid   = req_chan.queue_number;
   assign req_entry.kind  = req_chan.event_kind;

   // Controller.
   epq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Datapath.
   epq_store u_store (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .req_action    (req_chan.action),
      .req_entry     (req_entry),
      .rsp_status    (rsp_chan.status),
      .rsp_entry     (rsp_entry),
      .rsp_occupancy (rsp_chan.occupancy)
   );

   assign rsp_chan.out_scheduled_time      = rsp_entry.sched;
   assign rsp_chan.out_queue_arrival_time  = rsp_entry.q_arr;
   assign rsp_chan.out_system_arrival_time = rsp_entry.s_arr;
   assign rsp_chan.out_queue_number        = rsp_entry.qid;
   assign rsp_chan.out_event_kind          = rsp_entry.kind;

`ifndef NO_ASSERTIONS
   // A pending response blocks new requests.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while response pending");

   // An empty report always shows an empty store.
   a_empty_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == epq_pkg::STAT_EMPTY)
         |-> rsp_chan.occupancy == '0)
      else $error("empty status with nonzero occupancy");

   // A full report always shows a full store.
   a_full_occ: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && rsp_chan.status == epq_pkg::STAT_FULL)
         |-> rsp_chan.occupancy == epq_pkg::CNT_W'(epq_pkg::DEPTH))
      else $error("full status with store not full");
`endif

endmodule

// File: hw/rtl/epq_ctrl.sv
// ----------------------------------------------------------------------------
// Event priority queue controller
// Sequences load, compare, update and response for one word at a time.
// ----------------------------------------------------------------------------
module epq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output epq_pkg::cmd_type cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_COMP = 2'd1;
   localparam logic [1:0] ST_UPD  = 2'd2;
   localparam logic [1:0] ST_RESP = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Handshake and commands follow the state.
   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_RESP);
   assign cmd.load   = req_valid && req_ready;
   assign cmd.comp   = (state_ff == ST_COMP);
   assign cmd.update = (state_ff == ST_UPD);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (req_valid) state_in = ST_COMP;
         ST_COMP: state_in = ST_UPD;
         ST_UPD:  state_in = ST_RESP;
         ST_RESP: if (rsp_ready) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hw/rtl/epq_store.sv
// ----------------------------------------------------------------------------
// Event priority queue datapath
// Sorted row of event cells, each with its own comparator and shift path.
// ----------------------------------------------------------------------------
module epq_store (
   input  logic                       clock,
   input  logic                       reset,
   input  epq_pkg::cmd_type           cmd,
   input  logic                       req_action,
   input  epq_pkg::entry_type         req_entry,
   output logic [epq_pkg::STAT_W-1:0] rsp_status,
   output epq_pkg::entry_type         rsp_entry,
   output logic [epq_pkg::CNT_W-1:0]  rsp_occupancy
);

   localparam int DEPTH = epq_pkg::DEPTH;
   localparam int CNT_W = epq_pkg::CNT_W;

   epq_pkg::entry_type slot_ff [DEPTH];
   epq_pkg::entry_type new_ff;
   logic               act_ff;
   logic [DEPTH-1:0]   take_ff;
   logic [DEPTH-1:0]   take_in;
   logic [DEPTH-1:0]   after_pos;
   logic [CNT_W-1:0]   count_ff;

   logic do_ins;
   logic do_ext;

   assign do_ins = cmd.update && (act_ff == epq_pkg::ACT_INSERT) &&
                   (count_ff != CNT_W'(DEPTH));
   assign do_ext = cmd.update && (act_ff == epq_pkg::ACT_EXTRACT) &&
                   (count_ff != '0);

   // Every bit from the first taking cell upward is set.
   assign after_pos = take_ff | (~take_ff + DEPTH'(1));

   // Capture the request word, and the compare result in the compare state.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         act_ff <= req_action;
         new_ff <= req_entry;
      end
      if (cmd.comp) begin
         take_ff <= take_in;
      end
   end

   // Row of cells: compare, then shift in or shift out.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [1:0] ord;
      assign ord = epq_pkg::order_f(new_ff, slot_ff[i]);
      if (i == 0) begin : g_head
         assign take_in[i] = (CNT_W'(i) < count_ff) && ord[1];
      end else begin : g_body
         assign take_in[i] = (CNT_W'(i) < count_ff) && ord[0];
      end

      always_ff @(posedge clock) begin
         if (do_ins && (CNT_W'(i) <= count_ff)) begin
            if (i > 0 && after_pos[(i > 0) ? i - 1 : 0]) begin
               slot_ff[i] <= slot_ff[(i > 0) ? i - 1 : 0];
            end else if (after_pos[i] || (CNT_W'(i) == count_ff)) begin
               slot_ff[i] <= new_ff;
            end
         end else if (do_ext && (i < DEPTH - 1)) begin
            slot_ff[i] <= slot_ff[(i < DEPTH - 1) ? i + 1 : i];
         end
      end
   end

   // Entry count.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (do_ins) begin
         count_ff <= count_ff + CNT_W'(1);
      end else if (do_ext) begin
         count_ff <= count_ff - CNT_W'(1);
      end
   end

   // Response register, filled on the update cycle.
   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_entry <= do_ext ? slot_ff[0] : '0;
         if (act_ff == epq_pkg::ACT_INSERT) begin
            rsp_status    <= do_ins ? epq_pkg::STAT_DONE : epq_pkg::STAT_FULL;
            rsp_occupancy <= do_ins ? count_ff + CNT_W'(1) : count_ff;
         end else begin
            rsp_status    <= do_ext ? epq_pkg::STAT_DONE : epq_pkg::STAT_EMPTY;
            rsp_occupancy <= do_ext ? count_ff - CNT_W'(1) : count_ff;
         end
      end
   end

endmodule
